@@ rtl/sgkp_pkg.sv @@
// shared types, constants and gait keyframe table for the servo gait pwm block
// no dependencies; imported by servo_gait_keyframe_pwm
`default_nettype none

package sgkp_pkg;

   localparam int NUM_SERVOS = 3;
   localparam int MAX_FRAMES = 2;
   localparam int NUM_GAITS  = 5;

   localparam int PeriodW = 10;
   localparam int ScaleW  = 4;
   localparam int PulseW  = 6;   // widest pulse in the table is 50
   localparam int DelayW  = 5;   // longest delay in the table is 20
   localparam int TargetW = DelayW + ScaleW;
   localparam int MsW     = 12;
   localparam int FrameW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int LenW    = $clog2(MAX_FRAMES + 1);
   localparam int ByteW   = 8;
   localparam int RspDataW = 16;

   localparam logic [PeriodW-1:0] PERIOD_RESET = PeriodW'(627);
   localparam logic [ScaleW-1:0]  SCALE_RESET  = ScaleW'(10);

   // received command bytes
   localparam logic [ByteW-1:0] CMD_LED_ON   = 8'h31;   // '1'
   localparam logic [ByteW-1:0] CMD_LED_OFF  = 8'h32;   // '2'
   localparam logic [ByteW-1:0] CMD_STOP     = 8'h73;   // 's'
   localparam logic [ByteW-1:0] CMD_FORWARD  = 8'h66;   // 'f'
   localparam logic [ByteW-1:0] CMD_BACK     = 8'h62;   // 'b'
   localparam logic [ByteW-1:0] CMD_LEFT     = 8'h6C;   // 'l'
   localparam logic [ByteW-1:0] CMD_RIGHT    = 8'h72;   // 'r'

   typedef enum logic [1:0] {
      OP_PWM_TICK = 2'd0,
      OP_MS_TICK  = 2'd1,
      OP_COMMAND  = 2'd2,
      OP_RESERVED = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      GAIT_STOP    = 3'd0,
      GAIT_FORWARD = 3'd1,
      GAIT_BACK    = 3'd2,
      GAIT_LEFT    = 3'd3,
      GAIT_RIGHT   = 3'd4
   } gait_type;

   typedef enum logic [0:0] {
      CSR_PWM_PERIOD  = 1'b0,
      CSR_DELAY_SCALE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [NUM_SERVOS-1:0][PulseW-1:0] pulse;   // [0] center, [1] right, [2] left
      logic [DelayW-1:0]                 delay;
   } frame_type;

   function automatic frame_type mk_frame(input int p0, input int p1, input int p2,
                                          input int d);
      frame_type fr;
      fr.pulse[0] = PulseW'(p0);
      fr.pulse[1] = PulseW'(p1);
      fr.pulse[2] = PulseW'(p2);
      fr.delay    = DelayW'(d);
      return fr;
   endfunction

   function automatic logic [LenW-1:0] gait_len(input gait_type g);
      logic [LenW-1:0] n;
      unique case (g)
         GAIT_STOP: n = LenW'(1);
         default:   n = LenW'(2);
      endcase
      return n;
   endfunction

   function automatic frame_type gait_frame(input gait_type g, input logic [FrameW-1:0] f);
      frame_type fr;
      unique case (g)
         GAIT_FORWARD: fr = (f == '0) ? mk_frame(35, 30, 30, 20) : mk_frame(45, 50, 50, 20);
         GAIT_BACK:    fr = (f == '0) ? mk_frame(35, 40, 50, 20) : mk_frame(45, 30, 40, 20);
         GAIT_LEFT:    fr = (f == '0) ? mk_frame(35, 30, 50, 20) : mk_frame(45, 40, 30, 20);
         GAIT_RIGHT:   fr = (f == '0) ? mk_frame(35, 50, 30, 20) : mk_frame(45, 30, 50, 20);
         default:      fr = mk_frame(40, 40, 40, 1);
      endcase
      return fr;
   endfunction

endpackage

`default_nettype wire

@@ rtl/servo_gait_keyframe_pwm.sv @@
// three-channel servo pwm with gait keyframe sequencer and command byte decode
// depends on sgkp_pkg (types, gait table, command codes)
// each response beat is registered and appears in the cycle after its request beat is accepted
// throughput: one beat per cycle while responses are read; the only loop is the single state update per beat
// the response register stalls the request side only while a result waits unread
// reset (synchronous, active high): pwm count 0, pins low, stop gait frame 0,
// ms count 0, led lit, period 627, scale 10, no response pending
`default_nettype none

module servo_gait_keyframe_pwm (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_tvalid,
   output      logic                          req_tready,
   input  wire logic [7:0]                    req_tdata,   // [7:0] command_byte
   input  wire logic [1:0]                    req_tuser,   // [1:0] opcode
   // response channel
   output      logic                          rsp_tvalid,
   input  wire logic                          rsp_tready,
   // [0] center_pin, [1] right_pin, [2] left_pin, [3] led_level,
   // [11:4] echo_byte, [15:12] zero
   output      logic [sgkp_pkg::RspDataW-1:0] rsp_tdata,
   output      logic                          rsp_tuser,   // [0] echo_valid
   // configuration write channel
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic                          csr_index,
   input  wire logic [sgkp_pkg::PeriodW-1:0]  csr_data
);
   import sgkp_pkg::*;

   // configuration registers
   logic [PeriodW-1:0] period_ff, period_in;
   logic [ScaleW-1:0]  scale_ff, scale_in;

   // sequencer and pwm state
   logic [PeriodW-1:0]    pwm_count_ff, pwm_count_in;
   logic [NUM_SERVOS-1:0] pins_ff, pins_in;
   gait_type              gait_ff, gait_in;
   logic [FrameW-1:0]     frame_ff, frame_in;
   logic [MsW-1:0]        ms_count_ff, ms_count_in;
   logic                  led_ff, led_in;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  echo_valid_ff, echo_valid_in;
   logic [ByteW-1:0]      echo_byte_ff, echo_byte_in;

   logic       req_accept;
   logic       csr_accept;
   opcode_type opcode;
   frame_type  active_frame;
   logic [TargetW-1:0]    ms_target;
   logic [MsW-1:0]        ms_inc;
   logic [PeriodW-1:0]    pwm_base;
   logic [NUM_SERVOS-1:0] pins_base;
   logic [FrameW-1:0]     frame_step;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign opcode     = opcode_type'(req_tuser);

   // the active frame always follows the selected gait and frame index
   assign active_frame = gait_frame(gait_ff, frame_ff);
   assign ms_target    = TargetW'(active_frame.delay * scale_ff);
   assign ms_inc       = ms_count_ff + MsW'(1);

   // wrap the pwm counter first, then compare against the pulse widths
   assign pwm_base  = (pwm_count_ff >= period_ff) ? '0 : pwm_count_ff;
   assign pins_base = (pwm_count_ff >= period_ff) ? '1 : pins_ff;

   // next frame, wrapping at the gait length
   always_comb begin
      if ((LenW'(frame_ff) + LenW'(1)) >= gait_len(gait_ff)) begin
         frame_step = '0;
      end else begin
         frame_step = frame_ff + FrameW'(1);
      end
   end

   // configuration writes
   always_comb begin
      period_in = period_ff;
      scale_in  = scale_ff;
      if (csr_accept) begin
         unique case (csr_index_type'(csr_index))
            CSR_PWM_PERIOD:  period_in = csr_data;
            CSR_DELAY_SCALE: scale_in  = csr_data[ScaleW-1:0];
            default:         period_in = period_ff;
         endcase
      end
   end

   // per-beat state update
   always_comb begin
      pwm_count_in  = pwm_count_ff;
      pins_in       = pins_ff;
      gait_in       = gait_ff;
      frame_in      = frame_ff;
      ms_count_in   = ms_count_ff;
      led_in        = led_ff;
      echo_valid_in = echo_valid_ff;
      echo_byte_in  = echo_byte_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      if (req_accept) begin
         rsp_valid_in  = 1'b1;
         echo_valid_in = 1'b0;
         echo_byte_in  = '0;
         unique case (opcode)
            OP_PWM_TICK: begin
               pins_in = pins_base;
               for (int i = 0; i < NUM_SERVOS; i++) begin
                  if (pwm_base >= PeriodW'(active_frame.pulse[i])) begin
                     pins_in[i] = 1'b0;
                  end
               end
               pwm_count_in = pwm_base + PeriodW'(1);
            end
            OP_MS_TICK: begin
               if (ms_inc >= MsW'(ms_target)) begin
                  ms_count_in = '0;
                  frame_in    = frame_step;
               end else begin
                  ms_count_in = ms_inc;
               end
            end
            OP_COMMAND: begin
               echo_valid_in = 1'b1;
               echo_byte_in  = req_tdata;
               unique case (req_tdata)
                  CMD_LED_ON:  led_in = 1'b1;
                  CMD_LED_OFF: led_in = 1'b0;
                  CMD_STOP: begin
                     gait_in = GAIT_STOP;
                     frame_in = '0;
                     ms_count_in = '0;
                  end
                  CMD_FORWARD: begin
                     gait_in = GAIT_FORWARD;
                     frame_in = '0;
                     ms_count_in = '0;
                  end
                  CMD_BACK: begin
                     gait_in = GAIT_BACK;
                     frame_in = '0;
                     ms_count_in = '0;
                  end
                  CMD_LEFT: begin
                     gait_in = GAIT_LEFT;
                     frame_in = '0;
                     ms_count_in = '0;
                  end
                  CMD_RIGHT: begin
                     gait_in = GAIT_RIGHT;
                     frame_in = '0;
                     ms_count_in = '0;
                  end
                  default: begin
                     // unknown byte: echo only
                     led_in = led_ff;
                  end
               endcase
            end
            default: begin
               // reserved opcode: report current levels, no state change
               pins_in = pins_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= PERIOD_RESET;
         scale_ff     <= SCALE_RESET;
         pwm_count_ff <= '0;
         pins_ff      <= '0;
         gait_ff      <= GAIT_STOP;
         frame_ff     <= '0;
         ms_count_ff  <= '0;
         led_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         period_ff    <= period_in;
         scale_ff     <= scale_in;
         pwm_count_ff <= pwm_count_in;
         pins_ff      <= pins_in;
         gait_ff      <= gait_in;
         frame_ff     <= frame_in;
         ms_count_ff  <= ms_count_in;
         led_ff       <= led_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      echo_valid_ff <= echo_valid_in;
      echo_byte_ff  <= echo_byte_in;
   end

   // pins and led are live state; they only move on an accepted beat,
   // so they match the pending response while it waits
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = echo_valid_ff;
   assign rsp_tdata  = {{(RspDataW - ByteW - NUM_SERVOS - 1){1'b0}},
                        echo_byte_ff, led_ff, pins_ff};

`ifndef SYNTHESIS
   a_frame_in_gait: assert property (@(posedge clock) disable iff (reset)
      LenW'(frame_ff) < gait_len(gait_ff))
      else $error("frame index beyond gait length");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted beat produced no response");

   a_no_echo_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !echo_valid_ff) |-> (echo_byte_ff == '0))
      else $error("echo byte set without echo flag");

   a_stop_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_accept && opcode == OP_COMMAND && req_tdata == CMD_STOP)
         |=> (gait_ff == GAIT_STOP && frame_ff == '0 && ms_count_ff == '0))
      else $error("stop command did not restart the stop gait");

   a_state_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (!$past(req_accept) && !$past(reset)) |-> $stable({pins_ff, led_ff, gait_ff, frame_ff}))
      else $error("sequencer state moved without an accepted beat");
`endif

endmodule

`default_nettype wire
